>>> src/int_value_cache_delta_coder_assert.svh
// Assertion macros for the value cache delta coder.
// Depends on clk_i and rst_ni in the module that includes this file.
`ifndef INT_VALUE_CACHE_DELTA_CODER_ASSERT_SVH
`define INT_VALUE_CACHE_DELTA_CODER_ASSERT_SVH

// check outside reset
`define IVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check at every edge, reset included
`define IVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

>>> src/ivc_pkg.sv
// Shared types, constants and a function of the value cache delta coder.
// No dependencies.
package ivc_pkg;

  localparam int DataWidth     = 32;
  localparam int OpW           = 2;
  localparam int IdxW          = 4;
  localparam int CfgW          = 5;
  localparam int BlkW          = 6;
  localparam int DefMaxEntries = 16;
  localparam int SlotCap       = 2;
  localparam int MinBlock      = 2;

  localparam logic [CfgW-1:0] CacheSizeRst = CfgW'(8);

  typedef enum logic [OpW-1:0] {
    OpEncode = 2'd0,
    OpGet    = 2'd1,
    OpInsert = 2'd2
  } op_e;

  typedef struct packed {
    logic                 start;
    logic                 insert;
    logic [DataWidth-1:0] value;
    logic [DataWidth-1:0] mask;
  } delta_req_t;

  typedef struct packed {
    logic                 same;
    logic [DataWidth-1:0] data;
  } delta_rsp_t;

  function automatic logic [BlkW-1:0] block_size_f(logic [DataWidth-1:0] d,
                                                    logic [DataWidth-1:0] m);
    logic [DataWidth-1:0] r;
    logic [DataWidth-1:0] run;
    logic [DataWidth-1:0] cand;
    logic [BlkW-1:0]      pos;
    r    = m | DataWidth'(1);
    run  = r & ~(r + DataWidth'(1));
    cand = (d ^ (d << 1)) & run & ~DataWidth'(1);
    pos  = '0;
    for (int j = 1; j < DataWidth; j++) begin
      if (cand[j]) begin
        pos = BlkW'(j);
      end
    end
    if (pos == '0) begin
      return BlkW'(MinBlock);
    end
    return pos + 1'b1;
  endfunction

endpackage

>>> src/ivc_if.sv
// Request and response channel interfaces of the value cache delta coder.
// Depends on ivc_pkg.
interface ivc_req_if import ivc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       op;
  logic [DataWidth-1:0] value;
  logic [IdxW-1:0]      index;
  logic [DataWidth-1:0] mask;

  modport source (output valid, op, value, index, mask, input ready);
  modport sink   (input valid, op, value, index, mask, output ready);
endinterface

interface ivc_rsp_if import ivc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IdxW-1:0]      hit_index;
  logic [DataWidth-1:0] data_out;
  logic                 same_diff;
  logic [BlkW-1:0]      block_size;

  modport source (output valid, hit, hit_index, data_out, same_diff, block_size,
                  input ready);
  modport sink   (input valid, hit, hit_index, data_out, same_diff, block_size,
                  output ready);
endinterface

>>> src/int_value_cache_delta_coder.sv
// Value cache delta coder: a move-halfway-to-front recency cache of values,
// kept in one synchronous single-read single-write memory, plus delta state.
// Depends on ivc_pkg, ivc_if, ivc_delta and int_value_cache_delta_coder_assert.svh.
//
// One item is worked on at a time; the next is taken while the previous
// result still waits on the response channel. An encode starts a read and
// then walks the memory one entry per cycle until a hit or the last filled
// entry; every reordering moves one entry per cycle through the memory port
// and writes the new slot in the cycle after the last move. A miss or an
// insert passes through the delta unit (StDiff, then StDwait). The result
// is taken into the response register only while that register is free or
// being read out. No clearing pass after reset.
module int_value_cache_delta_coder import ivc_pkg::*; #(
  parameter int MAX_ENTRIES = DefMaxEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  ivc_req_if.sink         req_i,
  ivc_rsp_if.source       rsp_o
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int SzW  = (CntW > CfgW) ? CntW : CfgW;
  localparam int IcW  = (CntW > IdxW) ? CntW : IdxW;

  typedef enum logic [2:0] {
    StIdle, StSearch, StCapt, StDiff, StDwait, StShift, StFinal, StResp
  } state_e;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      cfg_size_q;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [CntW-1:0]      s_ra_q, s_ra_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [AW-1:0]        cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]        sh_cur_q, sh_cur_d;
  logic [AW-1:0]        sh_lo_q, sh_lo_d;
  logic                 wb_v_q, wb_v_d;
  logic [AW-1:0]        wb_addr_q, wb_addr_d;
  logic [DataWidth-1:0] wval_q, wval_d;
  logic [OpW-1:0]       op_q, op_d;
  logic [DataWidth-1:0] val_q, val_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [DataWidth-1:0] mask_q, mask_d;
  logic                 res_hit_q, res_hit_d;
  logic [IdxW-1:0]      res_hidx_q, res_hidx_d;
  logic [DataWidth-1:0] res_data_q, res_data_d;
  logic                 res_same_q, res_same_d;
  logic                 out_v_q, out_v_d;
  logic                 out_hit_q, out_hit_d;
  logic [IdxW-1:0]      out_hidx_q, out_hidx_d;
  logic [DataWidth-1:0] out_data_q, out_data_d;
  logic                 out_same_q, out_same_d;
  logic [BlkW-1:0]      out_blk_q, out_blk_d;

  logic [DataWidth-1:0] mem [MAX_ENTRIES];
  logic [DataWidth-1:0] rdata_q;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DataWidth-1:0] wdata;

  delta_req_t           dreq;
  delta_rsp_t           drsp;
  logic [BlkW-1:0]      blk_size;

  logic                 accept;
  logic [SzW-1:0]       cfg_ext;
  logic [SzW-1:0]       sz_ext;
  logic [CntW-1:0]      act_sz;
  logic                 fill_full;
  logic [CntW-1:0]      start_w;
  logic [CntW-1:0]      slot_w;

  ivc_delta u_delta (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (dreq),
    .rsp_o       (drsp),
    .block_size_o(blk_size)
  );

  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    cfg_ext = SzW'(cfg_size_q);
    sz_ext  = (cfg_ext == '0) ? SzW'(1) : cfg_ext;
    if (sz_ext > SzW'(MAX_ENTRIES)) begin
      sz_ext = SzW'(MAX_ENTRIES);
    end
    act_sz    = sz_ext[CntW-1:0];
    fill_full = (fill_q >= act_sz);
    start_w   = fill_full ? (act_sz - 1'b1) : fill_q;
    slot_w    = (fill_q < CntW'(SlotCap)) ? fill_q : CntW'(SlotCap);
    if (slot_w > start_w) begin
      slot_w = start_w;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    s_ra_d     = s_ra_q;
    cmp_v_d    = cmp_v_q;
    cmp_idx_d  = cmp_idx_q;
    sh_cur_d   = sh_cur_q;
    sh_lo_d    = sh_lo_q;
    wb_v_d     = 1'b0;
    wb_addr_d  = wb_addr_q;
    wval_d     = wval_q;
    op_d       = op_q;
    val_d      = val_q;
    idx_d      = idx_q;
    mask_d     = mask_q;
    res_hit_d  = res_hit_q;
    res_hidx_d = res_hidx_q;
    res_data_d = res_data_q;
    res_same_d = res_same_q;
    out_v_d    = out_v_q && !rsp_o.ready;
    out_hit_d  = out_hit_q;
    out_hidx_d = out_hidx_q;
    out_data_d = out_data_q;
    out_same_d = out_same_q;
    out_blk_d  = out_blk_q;
    raddr      = '0;
    we         = wb_v_q;
    waddr      = wb_addr_q;
    wdata      = rdata_q;
    dreq       = '0;
    dreq.value = val_q;
    dreq.mask  = mask_q;

    unique case (state_q)
      StIdle: begin
        raddr = AW'(req_i.index);
        if (accept) begin
          op_d       = req_i.op;
          val_d      = req_i.value;
          idx_d      = AW'(req_i.index);
          mask_d     = req_i.mask;
          res_hit_d  = 1'b0;
          res_hidx_d = '0;
          res_data_d = '0;
          res_same_d = 1'b0;
          unique case (op_e'(req_i.op))
            OpEncode: begin
              s_ra_d  = '0;
              cmp_v_d = 1'b0;
              state_d = (fill_q == '0) ? StDiff : StSearch;
            end
            OpGet: begin
              state_d = (IcW'(req_i.index) < IcW'(fill_q)) ? StCapt : StResp;
            end
            OpInsert: begin
              state_d = StDiff;
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end
      StSearch: begin
        raddr = s_ra_q[AW-1:0];
        if (cmp_v_q && (rdata_q == val_q)) begin
          res_hit_d  = 1'b1;
          res_hidx_d = IdxW'(cmp_idx_q);
          if (cmp_idx_q == '0) begin
            state_d = StResp;
          end else begin
            sh_cur_d = cmp_idx_q;
            sh_lo_d  = cmp_idx_q >> 1;
            wval_d   = val_q;
            state_d  = StShift;
          end
        end else if (cmp_v_q && (CntW'(cmp_idx_q) == fill_q - 1'b1)) begin
          state_d = StDiff;
        end else begin
          cmp_v_d   = (s_ra_q < fill_q);
          cmp_idx_d = s_ra_q[AW-1:0];
          if (s_ra_q < fill_q) begin
            s_ra_d = s_ra_q + 1'b1;
          end
        end
      end
      StCapt: begin
        res_data_d = rdata_q;
        if (idx_q == '0) begin
          state_d = StResp;
        end else begin
          sh_cur_d = idx_q;
          sh_lo_d  = idx_q >> 1;
          wval_d   = rdata_q;
          state_d  = StShift;
        end
      end
      StDiff: begin
        dreq.start  = 1'b1;
        dreq.insert = (op_q == OpInsert);
        state_d     = StDwait;
      end
      StDwait: begin
        res_same_d = drsp.same;
        res_data_d = drsp.data;
        wval_d     = (op_q == OpInsert) ? drsp.data : val_q;
        if (!fill_full) begin
          fill_d = fill_q + 1'b1;
        end
        sh_cur_d = start_w[AW-1:0];
        sh_lo_d  = slot_w[AW-1:0];
        state_d  = (start_w == slot_w) ? StFinal : StShift;
      end
      StShift: begin
        raddr     = sh_cur_q - 1'b1;
        wb_v_d    = 1'b1;
        wb_addr_d = sh_cur_q;
        sh_cur_d  = sh_cur_q - 1'b1;
        if ((sh_cur_q - 1'b1) == sh_lo_q) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        if (!wb_v_q) begin
          we      = 1'b1;
          waddr   = sh_lo_q;
          wdata   = wval_q;
          state_d = StResp;
        end
      end
      StResp: begin
        if (!out_v_q || rsp_o.ready) begin
          out_v_d    = 1'b1;
          out_hit_d  = res_hit_q;
          out_hidx_d = res_hidx_q;
          out_data_d = res_data_q;
          out_same_d = res_same_q;
          out_blk_d  = blk_size;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cfg_size_q <= CacheSizeRst;
      fill_q     <= '0;
      s_ra_q     <= '0;
      cmp_v_q    <= 1'b0;
      cmp_idx_q  <= '0;
      sh_cur_q   <= '0;
      sh_lo_q    <= '0;
      wb_v_q     <= 1'b0;
      wb_addr_q  <= '0;
      wval_q     <= '0;
      op_q       <= '0;
      val_q      <= '0;
      idx_q      <= '0;
      mask_q     <= '0;
      res_hit_q  <= 1'b0;
      res_hidx_q <= '0;
      res_data_q <= '0;
      res_same_q <= 1'b0;
      out_v_q    <= 1'b0;
      out_hit_q  <= 1'b0;
      out_hidx_q <= '0;
      out_data_q <= '0;
      out_same_q <= 1'b0;
      out_blk_q  <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        cfg_size_q <= cfg_wdata_i;
      end
      fill_q     <= fill_d;
      s_ra_q     <= s_ra_d;
      cmp_v_q    <= cmp_v_d;
      cmp_idx_q  <= cmp_idx_d;
      sh_cur_q   <= sh_cur_d;
      sh_lo_q    <= sh_lo_d;
      wb_v_q     <= wb_v_d;
      wb_addr_q  <= wb_addr_d;
      wval_q     <= wval_d;
      op_q       <= op_d;
      val_q      <= val_d;
      idx_q      <= idx_d;
      mask_q     <= mask_d;
      res_hit_q  <= res_hit_d;
      res_hidx_q <= res_hidx_d;
      res_data_q <= res_data_d;
      res_same_q <= res_same_d;
      out_v_q    <= out_v_d;
      out_hit_q  <= out_hit_d;
      out_hidx_q <= out_hidx_d;
      out_data_q <= out_data_d;
      out_same_q <= out_same_d;
      out_blk_q  <= out_blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign req_i.ready      = (state_q == StIdle);
  assign rsp_o.valid      = out_v_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.hit_index  = out_hidx_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.same_diff  = out_same_q;
  assign rsp_o.block_size = out_blk_q;

  `include "int_value_cache_delta_coder_assert.svh"

  `IVC_ASSERT_ALWAYS(a_fill_bound, fill_q <= CntW'(MAX_ENTRIES), "fill count above depth")
  `IVC_ASSERT(a_fill_step, (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1), "fill count moved by more than one")
  `IVC_ASSERT(a_busy_after_accept, accept |=> (state_q != StIdle), "idle right after an accepted beat")
  `IVC_ASSERT(a_wb_in_shift, wb_v_q |-> ((state_q == StShift) || (state_q == StFinal)), "write-back pending outside a shift")
  `IVC_ASSERT(a_out_from_resp, $rose(out_v_q) |-> ($past(state_q) == StResp), "response raised outside the response state")

endmodule

>>> src/ivc_delta.sv
// Delta coding state: last value, last difference and predicted block size.
// Two steps per request: form the difference, then compare and update.
// Depends on ivc_pkg.
module ivc_delta import ivc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  delta_req_t      req_i,
  output delta_rsp_t      rsp_o,
  output logic [BlkW-1:0] block_size_o
);

  logic                 pend_q, pend_d;
  logic                 ins_q, ins_d;
  logic [DataWidth-1:0] nd_q, nd_d;
  logic [DataWidth-1:0] val_q, val_d;
  logic [DataWidth-1:0] mask_q, mask_d;
  logic [DataWidth-1:0] last_value_q, last_value_d;
  logic [DataWidth-1:0] last_diff_q, last_diff_d;
  logic [BlkW-1:0]      pred_q, pred_d;

  logic                 same;
  logic [DataWidth-1:0] sum;

  assign same = (nd_q == last_diff_q);
  assign sum  = (last_value_q + val_q) & mask_q;

  always_comb begin
    pend_d       = 1'b0;
    ins_d        = ins_q;
    nd_d         = nd_q;
    val_d        = val_q;
    mask_d       = mask_q;
    last_value_d = last_value_q;
    last_diff_d  = last_diff_q;
    pred_d       = pred_q;
    if (req_i.start) begin
      pend_d = 1'b1;
      ins_d  = req_i.insert;
      val_d  = req_i.value;
      mask_d = req_i.mask;
      nd_d   = req_i.insert ? req_i.value : ((req_i.value - last_value_q) & req_i.mask);
    end
    if (pend_q) begin
      last_value_d = ins_q ? sum : (val_q & mask_q);
      if (!same) begin
        last_diff_d = nd_q;
        pred_d      = block_size_f(nd_q, mask_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      ins_q        <= 1'b0;
      nd_q         <= '0;
      val_q        <= '0;
      mask_q       <= '0;
      last_value_q <= '0;
      last_diff_q  <= '0;
      pred_q       <= '0;
    end else begin
      pend_q       <= pend_d;
      ins_q        <= ins_d;
      nd_q         <= nd_d;
      val_q        <= val_d;
      mask_q       <= mask_d;
      last_value_q <= last_value_d;
      last_diff_q  <= last_diff_d;
      pred_q       <= pred_d;
    end
  end

  assign rsp_o.same   = same;
  assign rsp_o.data   = ins_q ? sum : nd_q;
  assign block_size_o = pred_q;

endmodule
